// ----- rtl/linear_key_value_table_assert.svh -----
// ----------------------------------------------------------------------------
// linear key-value table assertion macros
// Shared property wrappers, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_KEY_VALUE_TABLE_ASSERT_SVH
`define LINEAR_KEY_VALUE_TABLE_ASSERT_SVH

// same-cycle implication
`define LKVT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lkvt: assertion failed");

// next-cycle implication
`define LKVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lkvt: assertion failed");

`endif

// ----- rtl/lkvt_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvt_pkg
// Types and constants shared by the linear key-value table modules.
// ----------------------------------------------------------------------------
package lkvt_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned KEY_BITS_DEF   = 64;
  localparam int unsigned VALUE_BITS_DEF = 64;

  // fixed widths of the port fields
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned OUTC_W  = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_FIND   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic [OUTC_W-1:0] {
    OUT_NOT_FOUND = 3'd0,
    OUT_FOUND     = 3'd1,
    OUT_ADDED     = 3'd2,
    OUT_REPLACED  = 3'd3,
    OUT_FULL      = 3'd4,
    OUT_REMOVED   = 3'd5
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_RESP
  } state_e;

endpackage

// ----- rtl/lkvt_ram.sv -----
// ----------------------------------------------------------------------------
// lkvt_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module lkvt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lkvt_ctrl.sv -----
// ----------------------------------------------------------------------------
// lkvt_ctrl
// Request sequencer: scans the key memory one entry per cycle, then replaces,
// appends or moves the last entry down, and presents one result per request.
// ----------------------------------------------------------------------------
module lkvt_ctrl #(
  parameter int unsigned DEPTH      = lkvt_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS   = lkvt_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lkvt_pkg::VALUE_BITS_DEF,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [lkvt_pkg::REQ_W-1:0] req_type_i,
  input  logic [KEY_BITS-1:0]      key_i,
  input  logic [VALUE_BITS-1:0]    value_i,
  output logic [AW-1:0]            raddr_o,
  output logic [AW-1:0]            waddr_o,
  output logic                     key_we_o,
  output logic [KEY_BITS-1:0]      key_wdata_o,
  input  logic [KEY_BITS-1:0]      key_rdata_i,
  output logic                     val_we_o,
  output logic [VALUE_BITS-1:0]    val_wdata_o,
  input  logic [VALUE_BITS-1:0]    val_rdata_i,
  output logic                     res_valid_o,
  input  logic                     res_take_i,
  output lkvt_pkg::outcome_e       res_outcome_o,
  output logic [VALUE_BITS-1:0]    res_value_o,
  output logic [CNT_W-1:0]         res_count_o
);

  lkvt_pkg::state_e   state_q, state_d;
  lkvt_pkg::req_e     req_q, req_d;
  lkvt_pkg::outcome_e outcome_q, outcome_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [VALUE_BITS-1:0] vout_q, vout_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  chk_q, chk_d;
  logic [AW-1:0]         chk_idx_q, chk_idx_d;
  logic [AW-1:0]         pos_q, pos_d;

  logic             accept;
  logic             hit;
  logic             more;
  logic             known_req;
  logic             room;
  logic [CNT_W-1:0] cnt_m1;

  assign accept    = in_valid_i && !in_stall_o;
  assign hit       = chk_q && (key_rdata_i == key_q);
  assign more      = idx_q < count_q;
  assign room      = count_q < CNT_W'(DEPTH);
  assign cnt_m1    = count_q - CNT_W'(1);
  assign known_req = (req_type_i == lkvt_pkg::REQ_FIND) ||
                     (req_type_i == lkvt_pkg::REQ_ADD)  ||
                     (req_type_i == lkvt_pkg::REQ_REMOVE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lkvt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = known_req ? lkvt_pkg::ST_SCAN : lkvt_pkg::ST_RESP;
        end
      end
      lkvt_pkg::ST_SCAN: begin
        if (hit) begin
          if (req_q == lkvt_pkg::REQ_REMOVE && chk_idx_q != cnt_m1[AW-1:0]) begin
            state_d = lkvt_pkg::ST_MOVE_RD;
          end else begin
            state_d = lkvt_pkg::ST_RESP;
          end
        end else if (!more) begin
          state_d = lkvt_pkg::ST_RESP;
        end
      end
      lkvt_pkg::ST_MOVE_RD: state_d = lkvt_pkg::ST_MOVE_WR;
      lkvt_pkg::ST_MOVE_WR: state_d = lkvt_pkg::ST_RESP;
      lkvt_pkg::ST_RESP: begin
        if (res_take_i) begin
          state_d = lkvt_pkg::ST_IDLE;
        end
      end
      default: state_d = lkvt_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    raddr_o     = idx_q[AW-1:0];
    waddr_o     = chk_idx_q;
    key_we_o    = 1'b0;
    key_wdata_o = key_q;
    val_we_o    = 1'b0;
    val_wdata_o = val_q;
    req_d       = req_q;
    key_d       = key_q;
    val_d       = val_q;
    outcome_d   = outcome_q;
    vout_d      = vout_q;
    idx_d       = idx_q;
    count_d     = count_q;
    chk_d       = chk_q;
    chk_idx_d   = chk_idx_q;
    pos_d       = pos_q;
    case (state_q)
      lkvt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          req_d     = lkvt_pkg::req_e'(req_type_i);
          key_d     = key_i;
          val_d     = value_i;
          outcome_d = lkvt_pkg::OUT_NOT_FOUND;
          vout_d    = '0;
          idx_d     = '0;
          chk_d     = 1'b0;
        end
      end
      lkvt_pkg::ST_SCAN: begin
        if (hit) begin
          chk_d = 1'b0;
          case (req_q)
            lkvt_pkg::REQ_FIND: begin
              outcome_d = lkvt_pkg::OUT_FOUND;
              vout_d    = val_rdata_i;
            end
            lkvt_pkg::REQ_ADD: begin
              val_we_o  = 1'b1;
              outcome_d = lkvt_pkg::OUT_REPLACED;
            end
            lkvt_pkg::REQ_REMOVE: begin
              count_d   = cnt_m1;
              pos_d     = chk_idx_q;
              outcome_d = lkvt_pkg::OUT_REMOVED;
            end
            default: outcome_d = lkvt_pkg::OUT_NOT_FOUND;
          endcase
        end else if (more) begin
          chk_d     = 1'b1;
          chk_idx_d = idx_q[AW-1:0];
          idx_d     = idx_q + CNT_W'(1);
        end else begin
          chk_d = 1'b0;
          if (req_q == lkvt_pkg::REQ_ADD) begin
            if (room) begin
              waddr_o   = count_q[AW-1:0];
              key_we_o  = 1'b1;
              val_we_o  = 1'b1;
              count_d   = count_q + CNT_W'(1);
              outcome_d = lkvt_pkg::OUT_ADDED;
            end else begin
              outcome_d = lkvt_pkg::OUT_FULL;
            end
          end
        end
      end
      lkvt_pkg::ST_MOVE_RD: begin
        // count already points at the old last entry
        raddr_o = count_q[AW-1:0];
      end
      lkvt_pkg::ST_MOVE_WR: begin
        waddr_o     = pos_q;
        key_we_o    = 1'b1;
        key_wdata_o = key_rdata_i;
        val_we_o    = 1'b1;
        val_wdata_o = val_rdata_i;
      end
      lkvt_pkg::ST_RESP: begin
        res_valid_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkvt_pkg::ST_IDLE;
      count_q <= '0;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      chk_q   <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    key_q     <= key_d;
    val_q     <= val_d;
    outcome_q <= outcome_d;
    vout_q    <= vout_d;
    idx_q     <= idx_d;
    chk_idx_q <= chk_idx_d;
    pos_q     <= pos_d;
  end

  assign res_outcome_o = outcome_q;
  assign res_value_o   = vout_q;
  assign res_count_o   = count_q;

endmodule

// ----- rtl/linear_key_value_table.sv -----
// ----------------------------------------------------------------------------
// linear_key_value_table
// Bounded key-value table with in-order linear search over a key memory.
// ----------------------------------------------------------------------------
// Entries stay packed in slots 0 .. count-1 of a key memory and a value
// memory. Each request scans the stored keys one per cycle through the read
// port of the key memory, and a hit ends the scan early. A remove that hits an
// entry other than the last then moves the last entry into the freed slot.
// One request is in work at a time, and the finished result waits in an
// output register so the next request can be accepted while it is still
// stalled downstream. Keys are matched on their low KEY_BITS bits and
// values keep their low VALUE_BITS bits.
// ----------------------------------------------------------------------------
`include "linear_key_value_table_assert.svh"

module linear_key_value_table #(
  parameter int unsigned DEPTH      = lkvt_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS   = lkvt_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lkvt_pkg::VALUE_BITS_DEF,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lkvt_pkg::REQ_W-1:0]  req_type_i,
  input  logic [lkvt_pkg::KEY_W-1:0]  key_i,
  input  logic [lkvt_pkg::VAL_W-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lkvt_pkg::OUTC_W-1:0] outcome_o,
  output logic [lkvt_pkg::VAL_W-1:0]  value_out_o,
  output logic [CNT_W-1:0]            entry_count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [AW-1:0]         raddr;
  logic [AW-1:0]         waddr;
  logic                  key_we;
  logic [KEY_BITS-1:0]   key_wdata;
  logic [KEY_BITS-1:0]   key_rdata;
  logic                  val_we;
  logic [VALUE_BITS-1:0] val_wdata;
  logic [VALUE_BITS-1:0] val_rdata;

  logic                  res_valid;
  logic                  res_take;
  lkvt_pkg::outcome_e    res_outcome;
  logic [VALUE_BITS-1:0] res_value;
  logic [CNT_W-1:0]      res_count;

  logic                            out_valid_q, out_valid_d;
  logic [lkvt_pkg::OUTC_W-1:0]     outcome_q, outcome_d;
  logic [lkvt_pkg::VAL_W-1:0]      value_q, value_d;
  logic [CNT_W-1:0]                count_q, count_d;

  lkvt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (key_wdata),
    .raddr_i (raddr),
    .rdata_o (key_rdata)
  );

  lkvt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (waddr),
    .wdata_i (val_wdata),
    .raddr_i (raddr),
    .rdata_o (val_rdata)
  );

  lkvt_ctrl #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .key_i         (key_i[KEY_BITS-1:0]),
    .value_i       (value_i[VALUE_BITS-1:0]),
    .raddr_o       (raddr),
    .waddr_o       (waddr),
    .key_we_o      (key_we),
    .key_wdata_o   (key_wdata),
    .key_rdata_i   (key_rdata),
    .val_we_o      (val_we),
    .val_wdata_o   (val_wdata),
    .val_rdata_i   (val_rdata),
    .res_valid_o   (res_valid),
    .res_take_i    (res_take),
    .res_outcome_o (res_outcome),
    .res_value_o   (res_value),
    .res_count_o   (res_count)
  );

  // output beat register
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    outcome_d   = outcome_q;
    value_d     = value_q;
    count_d     = count_q;
    if (res_take) begin
      out_valid_d = 1'b1;
      outcome_d   = res_outcome;
      value_d     = lkvt_pkg::VAL_W'(res_value);
      count_d     = res_count;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    outcome_q <= outcome_d;
    value_q   <= value_d;
    count_q   <= count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = outcome_q;
  assign value_out_o   = value_q;
  assign entry_count_o = count_q;

  `LKVT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `LKVT_ASSERT_NOW(a_full_at_depth, out_valid_o && outcome_o == lkvt_pkg::OUT_FULL, entry_count_o == CNT_W'(DEPTH))
  `LKVT_ASSERT_NOW(a_value_only_on_find, out_valid_o && outcome_o != lkvt_pkg::OUT_FOUND, value_out_o == '0)

endmodule
